[src/bss_pkg.sv]
package bss_pkg;

  localparam int WORD_W     = 64;
  localparam int WORD_COUNT = 64;
  localparam int WIDX_W     = 6;
  localparam int BIT_W      = 6;
  localparam int ELEM_W     = 12;
  localparam int OP_W       = 4;
  localparam int CNT_W      = 13;
  localparam int USED_W     = 7;

  localparam logic [CNT_W-1:0] UNI_MAX   = CNT_W'(WORD_COUNT * WORD_W);
  localparam logic [CNT_W-1:0] UNI_RESET = CNT_W'(4096);

  localparam logic ST_DONE  = 1'b0;
  localparam logic ST_RANGE = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_CONTAINS   = 4'd0,
    OP_ADD        = 4'd1,
    OP_REMOVE     = 4'd2,
    OP_RESTRICT   = 4'd3,
    OP_CLEAR      = 4'd4,
    OP_AND_WORD   = 4'd5,
    OP_OR_WORD    = 4'd6,
    OP_XOR_WORD   = 4'd7,
    OP_COMPLEMENT = 4'd8,
    OP_COUNT      = 4'd9
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              last;
    logic [BIT_W-1:0]  bit_sel;
    logic [WORD_W-1:0] lmask;
  } alu_ctl_t;

endpackage

[src/bss_if.sv]
interface bss_in_if;
  import bss_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [ELEM_W-1:0] element;
  logic [WIDX_W-1:0] word_index;
  logic [WORD_W-1:0] operand_word;

  modport source(output valid, operation, element, word_index, operand_word, input ready);
  modport sink(input valid, operation, element, word_index, operand_word, output ready);
endinterface

interface bss_out_if;
  import bss_pkg::*;
  logic             valid;
  logic             ready;
  logic             member;
  logic [CNT_W-1:0] active_count;
  logic             status;

  modport source(output valid, member, active_count, status, input ready);
  modport sink(input valid, member, active_count, status, output ready);
endinterface

[src/bss_ram.sv]
module bss_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/bss_alu.sv]
module bss_alu
  import bss_pkg::*;
(
  input  alu_ctl_t          ctl,
  input  logic [WORD_W-1:0] rd_word,
  input  logic [WORD_W-1:0] opw,
  output logic [WORD_W-1:0] wr_word,
  output logic              member,
  output logic [BIT_W:0]    ones
);

  logic [WORD_W-1:0] bitm;
  logic [WORD_W-1:0] keep;

  always_comb begin
    bitm   = WORD_W'(1) << ctl.bit_sel;
    keep   = ctl.last ? ctl.lmask : '1;
    member = |(rd_word & bitm);
    ones   = (BIT_W+1)'($countones(rd_word & keep));
    case (ctl.op)
      OP_ADD:        wr_word = rd_word | bitm;
      OP_REMOVE:     wr_word = rd_word & ~bitm;
      OP_AND_WORD:   wr_word = (rd_word & opw) & keep;
      OP_OR_WORD:    wr_word = (rd_word | opw) & keep;
      OP_XOR_WORD:   wr_word = (rd_word ^ opw) & keep;
      OP_COMPLEMENT: wr_word = ~rd_word & keep;
      default:       wr_word = rd_word;
    endcase
  end

endmodule

[src/bitset_store_with_popcount.sv]
// Bitset store: up to 4096 elements held as 64 words of 64 bits in one RAM, with a
// flop valid bit per word so that reset and clear empty the set at once. One word
// in flight at a time; ready is high only while idle. Contains, add, remove and the
// and/or/xor word operations read the word from RAM, modify and write it back, then
// give the result. Restrict and clear update the set at accept, then give it.
// Complement and count walk the words in use one per cycle through the shared word
// unit, ceil(U/64) words in all, where U is universe_size capped at 4096. An element
// or word index outside the universe is ignored and gives status 1. Write universe_size only while idle.
module bitset_store_with_popcount
  import bss_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  bss_in_if.sink           in_ch,
  bss_out_if.source        out_ch
);

  typedef enum logic [1:0] {S_IDLE, S_RMW, S_WALK, S_DONE} state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    uni_r;
  op_t                 op_r, op_nxt, in_op;
  logic [ELEM_W-1:0]   el_r, el_nxt;
  logic [WIDX_W-1:0]   wi_r, wi_nxt;
  logic [WORD_W-1:0]   opw_r, opw_nxt;
  logic [WIDX_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                member_r, member_nxt;
  logic                status_r, status_nxt;
  logic [WORD_COUNT-1:0] vld_r, vld_nxt;
  logic                rd_vld_r;
  logic                out_valid_r, out_valid_nxt;
  logic                out_member_r, out_member_nxt;
  logic [CNT_W-1:0]    out_count_r, out_count_nxt;
  logic                out_status_r, out_status_nxt;

  logic [CNT_W-1:0]      u_eff;
  logic [USED_W-1:0]     used;
  logic [USED_W-1:0]     used_m1;
  logic [WORD_W-1:0]     lmask;
  logic [WORD_COUNT-1:0] used_mask;
  logic                  ram_we;
  logic [WIDX_W-1:0]     ram_waddr, ram_raddr;
  logic [WORD_W-1:0]     ram_wdata, ram_rdata, rd_word;
  alu_ctl_t              ctl;
  logic [WORD_W-1:0]     alu_word;
  logic                  alu_member;
  logic [BIT_W:0]        alu_ones;

  always_comb begin
    u_eff   = (uni_r > UNI_MAX) ? UNI_MAX : uni_r;
    used    = USED_W'(({1'b0, u_eff} + 14'd63) >> BIT_W);
    used_m1 = used - 7'd1;
    lmask   = (u_eff[BIT_W-1:0] == '0) ? '1
            : (WORD_W'(1) << u_eff[BIT_W-1:0]) - WORD_W'(1);
    for (int i = 0; i < WORD_COUNT; i++) begin
      used_mask[i] = (USED_W'(i) < used);
    end
  end

  assign rd_word = rd_vld_r ? ram_rdata : '0;
  assign in_op   = op_t'(in_ch.operation);

  always_comb begin
    ctl.op      = op_r;
    ctl.bit_sel = el_r[BIT_W-1:0];
    ctl.lmask   = lmask;
    ctl.last    = ({1'b0, (state_r == S_WALK) ? idx_r : wi_r} == used_m1);
  end

  bss_alu u_alu (
    .ctl     (ctl),
    .rd_word (rd_word),
    .opw     (opw_r),
    .wr_word (alu_word),
    .member  (alu_member),
    .ones    (alu_ones)
  );

  bss_ram #(.WIDTH(WORD_W), .DEPTH(WORD_COUNT)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.member       = out_member_r;
  assign out_ch.active_count = out_count_r;
  assign out_ch.status       = out_status_r;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    el_nxt         = el_r;
    wi_nxt         = wi_r;
    opw_nxt        = opw_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    member_nxt     = member_r;
    status_nxt     = status_r;
    vld_nxt        = vld_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_member_nxt = out_member_r;
    out_count_nxt  = out_count_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r;
    ram_wdata      = alu_word;
    ram_raddr      = idx_r + 6'd1;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt     = in_op;
          el_nxt     = in_ch.element;
          wi_nxt     = in_ch.word_index;
          opw_nxt    = in_ch.operand_word;
          idx_nxt    = '0;
          cnt_nxt    = '0;
          member_nxt = 1'b0;
          status_nxt = ST_DONE;
          state_nxt  = S_DONE;
          unique case (in_op) inside
            OP_CONTAINS, OP_ADD, OP_REMOVE: begin
              if ({1'b0, in_ch.element} >= u_eff) begin
                status_nxt = ST_RANGE;
              end else begin
                ram_raddr = in_ch.element[ELEM_W-1:BIT_W];
                state_nxt = S_RMW;
              end
            end
            OP_RESTRICT: begin
              if ({1'b0, in_ch.element} >= u_eff) begin
                status_nxt = ST_RANGE;
              end else begin
                vld_nxt   = (vld_r & ~used_mask)
                          | (WORD_COUNT'(1) << in_ch.element[ELEM_W-1:BIT_W]);
                ram_we    = 1'b1;
                ram_waddr = in_ch.element[ELEM_W-1:BIT_W];
                ram_wdata = WORD_W'(1) << in_ch.element[BIT_W-1:0];
              end
            end
            OP_CLEAR: begin
              vld_nxt = vld_r & ~used_mask;
            end
            OP_AND_WORD, OP_OR_WORD, OP_XOR_WORD: begin
              if ({1'b0, in_ch.word_index} >= used) begin
                status_nxt = ST_RANGE;
              end else begin
                ram_raddr = in_ch.word_index;
                state_nxt = S_RMW;
              end
            end
            OP_COMPLEMENT, OP_COUNT: begin
              ram_raddr = '0;
              if (used != '0) begin
                state_nxt = S_WALK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RMW: begin
        if (op_r == OP_CONTAINS) begin
          member_nxt = alu_member;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = (op_r == OP_ADD || op_r == OP_REMOVE) ? el_r[ELEM_W-1:BIT_W] : wi_r;
          vld_nxt[ram_waddr] = 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_WALK: begin
        if (op_r == OP_COMPLEMENT) begin
          ram_we         = 1'b1;
          vld_nxt[idx_r] = 1'b1;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(alu_ones);
        end
        if ({1'b0, idx_r} == used_m1) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + 6'd1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_member_nxt = member_r;
          out_count_nxt  = cnt_r;
          out_status_nxt = status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      uni_r       <= UNI_RESET;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        uni_r <= cfg_wdata;
      end
    end
    op_r         <= op_nxt;
    el_r         <= el_nxt;
    wi_r         <= wi_nxt;
    opw_r        <= opw_nxt;
    idx_r        <= idx_nxt;
    cnt_r        <= cnt_nxt;
    member_r     <= member_nxt;
    status_r     <= status_nxt;
    rd_vld_r     <= vld_r[ram_raddr];
    out_member_r <= out_member_nxt;
    out_count_r  <= out_count_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule
